// ----- hdl/svnn_pkg.sv -----
// svnn_pkg: shared types and constants for the sorted-value nearest neighbor core.
// No dependencies.
package svnn_pkg;
   localparam int unsigned VALUE_W = 16;
   localparam int unsigned INDEX_W = 6;
   localparam int unsigned STORE_DEPTH = 64;

   typedef struct packed {
      logic [VALUE_W-1:0] sample_value;
      logic               last_sample;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] element_index;
      logic [INDEX_W-1:0] neighbor_first;
      logic [INDEX_W-1:0] neighbor_second;
      logic [INDEX_W-1:0] neighbor_third;
      logic               end_of_row;
   } rsp_type;

   typedef struct packed {
      logic [VALUE_W-1:0] ent_value;
      logic [INDEX_W-1:0] ent_index;
   } entry_type;
endpackage

// ----- hdl/svnn_sorter.sv -----
// svnn_sorter: sorted store of (value, index) entries in one synchronous memory.
// Depends on svnn_pkg. Insertion walks down from the fill point one entry per cycle;
// two registered read ports serve the neighbor sweep.
module svnn_sorter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                insert,
   input  logic [svnn_pkg::VALUE_W-1:0]        ins_value,
   input  logic [svnn_pkg::INDEX_W-1:0]        ins_index,
   output logic                                busy,
   input  logic [svnn_pkg::INDEX_W-1:0]        rd_addr_a,
   input  logic [svnn_pkg::INDEX_W-1:0]        rd_addr_b,
   output svnn_pkg::entry_type                 rd_data_a,
   output svnn_pkg::entry_type                 rd_data_b
);
   localparam int unsigned AW = svnn_pkg::INDEX_W;

   svnn_pkg::entry_type entry_mem [svnn_pkg::STORE_DEPTH];
   svnn_pkg::entry_type rd_a_ff, rd_b_ff, new_ff, new_in, wr_data;
   logic [AW-1:0] j_ff, j_in, wr_addr, addr_a;
   logic walk_ff, walk_in, wr_en;

   // j is the hole; each step compares the entry just below it
   always_comb begin
      j_in = j_ff;
      new_in = new_ff;
      walk_in = walk_ff;
      wr_en = 1'b0;
      wr_addr = j_ff;
      wr_data = new_ff;
      if (walk_ff) begin
         wr_en = 1'b1;
         if (j_ff != '0 && rd_a_ff.ent_value > new_ff.ent_value) begin
            wr_data = rd_a_ff;
            j_in = j_ff - 1'b1;
         end else begin
            walk_in = 1'b0;
         end
      end else if (insert) begin
         j_in = ins_index;
         new_in.ent_value = ins_value;
         new_in.ent_index = ins_index;
         walk_in = 1'b1;
      end
      addr_a = (insert || walk_ff) ? j_in - 1'b1 : rd_addr_a;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= entry_mem[addr_a];
      rd_b_ff <= entry_mem[rd_addr_b];
   end

   always_ff @(posedge clock) begin
      j_ff <= j_in;
      new_ff <= new_in;
      if (reset) begin
         walk_ff <= 1'b0;
      end else begin
         walk_ff <= walk_in;
      end
   end

   assign busy = walk_ff;
   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;
endmodule

// ----- hdl/svnn_picker.sv -----
// svnn_picker: one neighbor pick from left/right candidates of the sorted row.
// Depends on svnn_pkg. Pure combinational compare of distances.
module svnn_picker (
   input  logic                         has_l,
   input  logic                         has_r,
   input  logic [svnn_pkg::VALUE_W-1:0] center,
   input  logic [svnn_pkg::VALUE_W-1:0] l_value,
   input  logic [svnn_pkg::VALUE_W-1:0] r_value,
   output logic                         take_l,
   output logic                         take_r
);
   logic [svnn_pkg::VALUE_W-1:0] dl, dr;
   assign dl = center - l_value;
   assign dr = r_value - center;
   always_comb begin
      take_l = 1'b0;
      take_r = 1'b0;
      if (has_l && has_r) begin
         if (dl < dr) take_l = 1'b1;
         else take_r = 1'b1;
      end else if (has_l) begin
         take_l = 1'b1;
      end else if (has_r) begin
         take_r = 1'b1;
      end
   end
endmodule

// ----- hdl/sorted_value_nearest_neighbors_core.sv -----
// sorted_value_nearest_neighbors_core: top level, load + sorted store + neighbor sweep.
// Depends on svnn_pkg, svnn_sorter, svnn_picker.
//
//  channel | dir | payload  | note
//  req     | in  | req_type | one sample per item
//  rsp     | out | rsp_type | one result per element after row closes
//
// A sample is accepted, then walks down the sorted store one entry per cycle past
// every larger entry already stored. After the row closes the sweep starts, and
// each result takes a center read, three picks and an output, which is held while
// rsp stalls. No item accepted while inserting or emitting. Synchronous
// active-high reset returns to an empty row.
module sorted_value_nearest_neighbors_core #(
   parameter int unsigned ROW_LENGTH_MAX = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  svnn_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output svnn_pkg::rsp_type rsp_data
);
   localparam int unsigned IW = svnn_pkg::INDEX_W;
   localparam int unsigned CW = svnn_pkg::INDEX_W + 1;
   localparam logic signed [CW:0] STEP = 1;

   typedef enum logic [4:0] {
      ST_LOAD = 5'b00001, ST_SORT = 5'b00010, ST_CENTER = 5'b00100,
      ST_PICK = 5'b01000, ST_OUT = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in, n_ff, n_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic signed [CW:0] l_ff, l_in, r_ff, r_in;
   logic [1:0] k_ff, k_in;
   svnn_pkg::rsp_type res_ff, res_in;
   logic [svnn_pkg::VALUE_W-1:0] ctr_ff, ctr_in;

   svnn_pkg::entry_type rd_a, rd_b;
   logic accept, busy, has_l, has_r, take_l, take_r;
   logic [IW-1:0] addr_a, addr_b;
   logic [IW-1:0] pick;

   assign req_ready = (state_ff == ST_LOAD) && !busy;
   assign accept = req_valid && req_ready;

   svnn_sorter u_sort (
      .clock(clock), .reset(reset), .insert(accept),
      .ins_value(req_data.sample_value), .ins_index(IW'(cnt_ff)), .busy(busy),
      .rd_addr_a(addr_a), .rd_addr_b(addr_b), .rd_data_a(rd_a), .rd_data_b(rd_b)
   );

   assign has_l = !l_ff[CW];
   assign has_r = (r_ff < $signed({1'b0, n_ff}));

   svnn_picker u_pick (
      .has_l(has_l), .has_r(has_r), .center(ctr_ff),
      .l_value(rd_a.ent_value), .r_value(rd_b.ent_value), .take_l(take_l), .take_r(take_r)
   );

   always_comb begin
      pick = take_l ? rd_a.ent_index : (take_r ? rd_b.ent_index : res_ff.element_index);
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      n_in = n_ff;
      pos_in = pos_ff;
      l_in = l_ff;
      r_in = r_ff;
      k_in = k_ff;
      res_in = res_ff;
      ctr_in = ctr_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               cnt_in = cnt_ff + 1'b1;
               if (req_data.last_sample || (cnt_ff + 1'b1 == CW'(ROW_LENGTH_MAX))) begin
                  n_in = cnt_ff + 1'b1;
                  cnt_in = '0;
                  pos_in = '0;
                  state_in = ST_SORT;
               end
            end
         end
         ST_SORT: begin
            if (!busy) state_in = ST_CENTER;
         end
         ST_CENTER: begin
            ctr_in = rd_a.ent_value;
            res_in.element_index = rd_a.ent_index;
            res_in.end_of_row = (pos_ff + 1'b1 == n_ff);
            l_in = $signed({1'b0, pos_ff}) - STEP;
            r_in = $signed({1'b0, pos_ff}) + STEP;
            k_in = '0;
            state_in = ST_PICK;
         end
         ST_PICK: begin
            if (take_l) l_in = l_ff - STEP;
            if (take_r) r_in = r_ff + STEP;
            case (k_ff)
               2'd0: res_in.neighbor_first = pick;
               2'd1: res_in.neighbor_second = pick;
               default: res_in.neighbor_third = pick;
            endcase
            k_in = k_ff + 1'b1;
            if (k_ff == 2'd2) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               pos_in = pos_ff + 1'b1;
               state_in = (pos_ff + 1'b1 == n_ff) ? ST_LOAD : ST_CENTER;
            end
         end
         default: state_in = ST_LOAD;
      endcase
      // reads issued here return data in the next state
      addr_a = (state_in == ST_CENTER) ? IW'(pos_in) : IW'(l_in);
      addr_b = IW'(r_in);
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      ctr_ff <= ctr_in;
      l_ff <= l_in;
      r_ff <= r_in;
      pos_ff <= pos_in;
      n_ff <= n_in;
      k_ff <= k_in;
      if (reset) begin
         state_ff <= ST_LOAD;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
   end

   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_data = res_ff;
endmodule

// ----- verif/tb_top.sv -----
// tb_top: self-checking testbench for sorted_value_nearest_neighbors_core.
// Feeds sample rows, predicts the three nearest neighbors of each element, checks results.
// Depends on svnn_pkg and the core RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ROW_MAX = 64;
   localparam int CYCLE_LIMIT = 400000;

   class neighbor_board;
      logic [15:0]       row_vals[ROW_MAX];
      int                row_fill;
      svnn_pkg::rsp_type pending[$];
      int                mismatches;

      function new();
         row_fill = 0;
         mismatches = 0;
      endfunction

      function void note_sample(svnn_pkg::req_type s);
         int order[ROW_MAX];
         int n, i, j, k, lft, rgt, self_idx, pick;
         logic [16:0] dl, dr;
         svnn_pkg::rsp_type r;
         row_vals[row_fill] = s.sample_value;
         row_fill++;
         if (!s.last_sample && row_fill < ROW_MAX) return;
         n = row_fill;
         row_fill = 0;
         for (i = 0; i < n; i++) begin
            j = i;
            while (j > 0 && row_vals[order[j-1]] > row_vals[i]) begin
               order[j] = order[j-1];
               j--;
            end
            order[j] = i;
         end
         for (i = 0; i < n; i++) begin
            self_idx = order[i];
            lft = i - 1;
            rgt = i + 1;
            r.element_index = self_idx[5:0];
            for (k = 0; k < 3; k++) begin
               if (lft >= 0 && rgt < n) begin
                  dl = row_vals[self_idx] - row_vals[order[lft]];
                  dr = row_vals[order[rgt]] - row_vals[self_idx];
                  if (dl < dr) begin pick = order[lft]; lft--; end
                  else begin pick = order[rgt]; rgt++; end
               end else if (lft >= 0) begin
                  pick = order[lft]; lft--;
               end else if (rgt < n) begin
                  pick = order[rgt]; rgt++;
               end else pick = self_idx;
               case (k)
                  0: r.neighbor_first = pick[5:0];
                  1: r.neighbor_second = pick[5:0];
                  default: r.neighbor_third = pick[5:0];
               endcase
            end
            r.end_of_row = (i == n - 1);
            pending.insert(pending.size(), r);
         end
      endfunction

      function void check_result(svnn_pkg::rsp_type got);
         svnn_pkg::rsp_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"result mismatch: expected idx=%0d n=%0d,%0d,%0d eor=%0d",
                         " got idx=%0d n=%0d,%0d,%0d eor=%0d"},
                  want.element_index, want.neighbor_first, want.neighbor_second,
                  want.neighbor_third, want.end_of_row, got.element_index,
                  got.neighbor_first, got.neighbor_second, got.neighbor_third,
                  got.end_of_row);
         end
      endfunction
   endclass

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_ready;
   svnn_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 0;
   svnn_pkg::rsp_type rsp_data;
   int                cycles = 0;
   neighbor_board     board = new();

   sorted_value_nearest_neighbors_core #(.ROW_LENGTH_MAX(ROW_MAX)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // receiver stall pattern: calm stretches alternate with occasional random stalling
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_result(rsp_data);
      if (reset) rsp_ready <= 0;
      else if (cycles[9]) rsp_ready <= 1;
      else rsp_ready <= ($urandom_range(0, 3) != 0);
   end

   int burst_left = 0;

   task automatic send_sample(input logic [15:0] v, input logic lst);
      svnn_pkg::req_type s;
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      s.sample_value = v;
      s.last_sample = lst;
      req_valid <= 1;
      req_data <= s;
      do @(posedge clock); while (!req_ready);
      board.note_sample(s);
   endtask

   task automatic send_row(input int len, input int mode);
      logic [15:0] v;
      int i;
      for (i = 0; i < len; i++) begin
         case (mode)
            0: v = 16'($urandom);
            1: v = 16'($urandom_range(0, 7) << $urandom_range(0, 12));
            2: v = 16'(16'h4000 + $urandom_range(0, 3));
            default: v = 16'(i * 7);
         endcase
         send_sample(v, (i == len - 1) && (len < ROW_MAX || $urandom_range(0, 1) == 1));
      end
   endtask

   int sent;
   int len;

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: extremes, single, pair, triple, ties and exact tie distances
      send_sample(16'hFFFF, 1);
      send_sample(16'h0000, 0);
      send_sample(16'hFFFF, 1);
      send_sample(16'd5, 0);
      send_sample(16'd5, 0);
      send_sample(16'd5, 1);
      send_sample(16'd10, 0);
      send_sample(16'd0, 0);
      send_sample(16'd20, 0);
      send_sample(16'd30, 0);
      send_sample(16'd11, 1);
      send_sample(16'h8000, 0);
      send_sample(16'h7FFF, 0);
      send_sample(16'h0001, 0);
      send_sample(16'hFFFE, 0);
      send_sample(16'h5555, 0);
      send_sample(16'hAAAA, 1);
      sent = 17;
      send_row(ROW_MAX, 3);
      sent += ROW_MAX;
      while (sent < 210) begin
         len = $urandom_range(0, 7) == 0 ? $urandom_range(30, ROW_MAX)
                                         : $urandom_range(1, 10);
         send_row(len, $urandom_range(0, 3));
         sent += len;
      end
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (board.mismatches == 0 && board.row_fill == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule
